// ===== sv/lre_pkg.sv =====
// lre_pkg: shared constants, types and table functions of the log rate encoder
// no dependencies; imported by every module of the block
`default_nettype none

package lre_pkg;

  // top-level defaults and fixed field widths
  localparam int unsigned DEPTH_DEFAULT = 65536;
  localparam int unsigned CODE_W        = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // configuration reset values
  localparam logic [31:0] START_RESET   = 32'd0;
  localparam logic [31:0] NOMINAL_RESET = 32'd10000000;
  localparam logic [30:0] LOW_RESET     = 31'd9000000;
  localparam logic [30:0] HIGH_RESET    = 31'd15000000;

  // log table construction
  localparam int unsigned HI_ENTRIES    = 256;
  localparam int unsigned LO_ENTRIES    = 128;
  localparam int unsigned PROBE_PROD_W  = 20;
  localparam logic [31:0] ENTRY_OFFSET  = 32'd1024;
  localparam logic [6:0]  PRODUCT_SHIFT = 7'd114;
  localparam logic [63:0] LN2_Q62       = 64'h2C5C_85FD_F473_DE6A;
  localparam logic [63:0] ONE_Q62       = 64'h4000_0000_0000_0000;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_STAMP,
    REG_NOMINAL,
    REG_LOW_BOUND,
    REG_HIGH_BOUND
  } lre_reg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [31:0] rx_delta;
    logic [31:0] tx_delta;
    logic [31:0] elapsed;
    logic        scale;
  } lre_job_t;

  // (a * b) >> 62 in unsigned q2.62
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // 2^(num / 2^frac_bits) in q2.62, num below 2^frac_bits, taylor series of exp
  function automatic logic [63:0] exp2_q62(input logic [31:0] num, input logic [4:0] frac_bits);
    logic [127:0] zp;
    logic [63:0]  z;
    logic [63:0]  term;
    logic [63:0]  sum;
    zp   = 128'(LN2_Q62) * 128'(num);
    z    = 64'(zp >> frac_bits);
    term = z;
    sum  = ONE_Q62 + term;
    term = q62_mul(term, z) / 64'd2;  sum = sum + term;
    term = q62_mul(term, z) / 64'd3;  sum = sum + term;
    term = q62_mul(term, z) / 64'd4;  sum = sum + term;
    term = q62_mul(term, z) / 64'd5;  sum = sum + term;
    term = q62_mul(term, z) / 64'd6;  sum = sum + term;
    term = q62_mul(term, z) / 64'd7;  sum = sum + term;
    term = q62_mul(term, z) / 64'd8;  sum = sum + term;
    term = q62_mul(term, z) / 64'd9;  sum = sum + term;
    term = q62_mul(term, z) / 64'd10; sum = sum + term;
    term = q62_mul(term, z) / 64'd11; sum = sum + term;
    term = q62_mul(term, z) / 64'd12; sum = sum + term;
    term = q62_mul(term, z) / 64'd13; sum = sum + term;
    term = q62_mul(term, z) / 64'd14; sum = sum + term;
    term = q62_mul(term, z) / 64'd15; sum = sum + term;
    term = q62_mul(term, z) / 64'd16; sum = sum + term;
    term = q62_mul(term, z) / 64'd17; sum = sum + term;
    term = q62_mul(term, z) / 64'd18; sum = sum + term;
    term = q62_mul(term, z) / 64'd19; sum = sum + term;
    term = q62_mul(term, z) / 64'd20; sum = sum + term;
    return sum;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lre_if.sv =====
// lre_if: valid/ready channel interfaces for samples in and codes out
// no dependencies
`default_nettype none

interface lre_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_stamp;
  logic [31:0] rx_count;
  logic [31:0] tx_count;
  logic [31:0] timestamp_us;

  modport source (output valid, output period_stamp, output rx_count, output tx_count,
                  output timestamp_us, input ready);
  modport sink (input valid, input period_stamp, input rx_count, input tx_count,
                input timestamp_us, output ready);
endinterface

interface lre_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        rx_code;
  logic [15:0]        tx_code;
  logic signed [31:0] elapsed_us;

  modport source (output valid, output rx_code, output tx_code, output elapsed_us,
                  input ready);
  modport sink (input valid, input rx_code, input tx_code, input elapsed_us,
                output ready);
endinterface

`default_nettype wire

// ===== sv/log_rate_encoder.sv =====
// log_rate_encoder: top level, configuration registers, front, queue and back
// depends on lre_pkg, lre_if, lre_front, lre_fifo and lre_back
//
//   channel   | kind          | word
//   ----------+---------------+------------------------------------------------
//   samples   | valid/ready   | period_stamp, rx_count, tx_count, timestamp_us
//   results   | valid/ready   | rx_code, tx_code, elapsed_us
//   cfg       | write enable  | cfg_index, cfg_data
//
// a priming sample only updates the stored counters in the front and yields no word
// a result sample reaches the output register after, for each lane that scales,
//   a 32x32 multiply, a saturation check and a bit-serial divide (the divide is
//   skipped when it saturates), then 16 search probes in each coder, each a fetch,
//   the four-step partial-product multiply for the entry and a compare
// a two-entry queue lets the front accept while the back is busy, and the
//   output register lets the back start the next word while a result waits
// synchronous reset clears the stored counters, primed flag and the queue;
//   the log tables are constant logic and need no clearing pass
`default_nettype none

module log_rate_encoder #(
  parameter int unsigned TABLE_DEPTH = lre_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lre_pkg::CFG_DATA_W-1:0]     cfg_data,
  lre_in_if.sink                                  samples,
  lre_out_if.source                               results
);
  import lre_pkg::*;

  logic [31:0] start_stamp;
  logic [31:0] nominal_us;
  logic [30:0] low_bound_us;
  logic [30:0] high_bound_us;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  lre_job_t q_in;
  lre_job_t q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_stamp   <= START_RESET;
      nominal_us    <= NOMINAL_RESET;
      low_bound_us  <= LOW_RESET;
      high_bound_us <= HIGH_RESET;
    end else if (cfg_we) begin
      case (lre_reg_t'(cfg_index))
        REG_START_STAMP: start_stamp   <= cfg_data[31:0];
        REG_NOMINAL:     nominal_us    <= cfg_data[31:0];
        REG_LOW_BOUND:   low_bound_us  <= cfg_data[30:0];
        REG_HIGH_BOUND:  high_bound_us <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // sample intake and classification
  lre_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start_stamp   (start_stamp),
    .low_bound_us  (low_bound_us),
    .high_bound_us (high_bound_us),
    .samples       (samples),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in)
  );

  // decoupling queue
  lre_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out),
    .empty    (q_empty)
  );

  // scaling and coding
  lre_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .nominal_us (nominal_us),
    .job        (q_out),
    .job_avail  (!q_empty),
    .job_take   (q_pop),
    .results    (results)
  );

endmodule

`default_nettype wire

// ===== sv/lre_front.sv =====
// lre_front: accepts samples, keeps the last counters and classifies each word
// depends on lre_pkg and lre_in_if
`default_nettype none

module lre_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       start_stamp,
  input  wire logic [30:0]       low_bound_us,
  input  wire logic [30:0]       high_bound_us,
  lre_in_if.sink                 samples,
  input  wire logic              q_full,
  output logic                   q_push,
  output lre_pkg::lre_job_t      q_job
);
  import lre_pkg::*;

  logic [31:0] rx_last;
  logic [31:0] tx_last;
  logic [31:0] time_last;
  logic        primed;

  logic        accept;
  logic        prime_only;
  logic [31:0] elapsed;

  // accept whenever the queue has room
  assign samples.ready = !q_full;
  assign accept        = samples.valid && samples.ready;

  // first word or early period stamp only re-primes
  assign prime_only = !primed || (samples.period_stamp < start_stamp);

  // deltas and scaling window, negative elapsed never scales
  assign elapsed = samples.timestamp_us - time_last;
  always_comb begin
    q_job.rx_delta = samples.rx_count - rx_last;
    q_job.tx_delta = samples.tx_count - tx_last;
    q_job.elapsed  = elapsed;
    q_job.scale    = !elapsed[31] && (elapsed[30:0] > low_bound_us) &&
                     (elapsed[30:0] < high_bound_us);
  end

  assign q_push = accept && !prime_only;

  // stored counters and time
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_last   <= '0;
      tx_last   <= '0;
      time_last <= '0;
      primed    <= 1'b0;
    end else if (accept) begin
      rx_last   <= samples.rx_count;
      tx_last   <= samples.tx_count;
      time_last <= samples.timestamp_us;
      primed    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lre_fifo.sv =====
// lre_fifo: short word queue between front and back
// depends on lre_pkg
`default_nettype none

module lre_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lre_pkg::lre_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output lre_pkg::lre_job_t      pop_job,
  output logic                   empty
);
  import lre_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  lre_job_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lre_coder.sv =====
// lre_coder: binary search of the exponential table, entries built from two
// constant mantissa tables and a four-step 32x32 partial-product multiply
// depends on lre_pkg
`default_nettype none

module lre_coder #(
  parameter int unsigned TABLE_DEPTH = lre_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [31:0]                value,
  output logic                            busy,
  output logic [lre_pkg::CODE_W-1:0]      code
);
  import lre_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] STEP_FIRST  = IDX_W'(1) << (IDX_W - 1);
  localparam logic [IDX_W-1:0] STEP_LAST   = IDX_W'(1);
  localparam logic [IDX_W:0]   DEPTH_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [2:0]       MUL_STEPS   = 3'd4;

  typedef enum logic [1:0] {C_IDLE, C_FETCH, C_MUL, C_CMP} state_t;

  state_t                  state;
  logic [31:0]             target;
  logic [IDX_W-1:0]        pos;
  logic [IDX_W-1:0]        step;
  logic [IDX_W-1:0]        probe_r;
  logic [4:0]              whole;
  logic [63:0]             a_r;
  logic [63:0]             b_r;
  logic [63:0]             pp;
  logic [1:0]              pp_sh;
  logic [2:0]              cnt;
  logic [127:0]            acc;

  logic [IDX_W:0]          probe;
  logic [PROBE_PROD_W-1:0] y;
  logic [31:0]             entry_val;
  logic [31:0]             entry;
  logic [31:0]             a_half;
  logic [31:0]             b_half;

  // 2^(k/256) and 2^(k/32768) mantissas, evaluated at elaboration
  logic [63:0] exp_hi [HI_ENTRIES];
  logic [63:0] exp_lo [LO_ENTRIES];

  for (genvar g = 0; g < HI_ENTRIES; g++) begin : g_hi
    localparam logic [63:0] MANT = exp2_q62(32'(g), 5'd8);
    assign exp_hi[g] = MANT;
  end

  for (genvar g = 0; g < LO_ENTRIES; g++) begin : g_lo
    localparam logic [63:0] MANT = exp2_q62(32'(g), 5'd15);
    assign exp_lo[g] = MANT;
  end

  // probe index and its exponent split: 11*i = whole*32768 + frac
  assign probe = {1'b0, pos} + {1'b0, step};
  assign y     = PROBE_PROD_W'(probe) * PROBE_PROD_W'(11);

  // partial-product operand halves
  assign a_half = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt[0] ? b_r[63:32] : b_r[31:0];

  // table entry from the q4.124 product
  assign entry_val = 32'(acc >> (PRODUCT_SHIFT - {2'b00, whole}));
  assign entry     = entry_val - ENTRY_OFFSET;

  assign busy = (state != C_IDLE);
  assign code = CODE_W'(pos);

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      pos   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            target <= value;
            pos    <= '0;
            step   <= STEP_FIRST;
            if (value != '0) begin
              state <= C_FETCH;
            end
          end
        end
        C_FETCH: begin
          if (probe < DEPTH_LIMIT) begin
            probe_r <= probe[IDX_W-1:0];
            whole   <= y[19:15];
            a_r     <= exp_hi[y[14:7]];
            b_r     <= exp_lo[y[6:0]];
            acc     <= '0;
            cnt     <= '0;
            state   <= C_MUL;
          end else begin
            step <= step >> 1;
            if (step == STEP_LAST) begin
              state <= C_IDLE;
            end
          end
        end
        C_MUL: begin
          if (cnt != MUL_STEPS) begin
            pp    <= {32'd0, a_half} * {32'd0, b_half};
            pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          end
          if (cnt != '0) begin
            acc <= acc + (128'(pp) << {pp_sh, 5'd0});
          end
          cnt <= cnt + 1'b1;
          if (cnt == MUL_STEPS) begin
            state <= C_CMP;
          end
        end
        C_CMP: begin
          if (entry <= target) begin
            pos <= probe_r;
          end
          step  <= step >> 1;
          state <= (step == STEP_LAST) ? C_IDLE : C_FETCH;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lre_back.sv =====
// lre_back: scales deltas (32x32 multiply, bit-serial divide), runs both
// coders and holds the result word in an output register
// depends on lre_pkg, lre_out_if and lre_coder
`default_nettype none

module lre_back #(
  parameter int unsigned TABLE_DEPTH = lre_pkg::DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       nominal_us,
  input  wire lre_pkg::lre_job_t job,
  input  wire logic              job_avail,
  output logic                   job_take,
  lre_out_if.source              results
);
  import lre_pkg::*;

  localparam logic [4:0]  DIV_LAST = 5'd31;
  localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHECK, B_DIV, B_CODE, B_WAIT, B_OUT} state_t;

  state_t      state;
  lre_job_t    job_r;
  logic        lane;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [31:0] num;
  logic [4:0]  cnt;
  logic [31:0] vrx;
  logic [31:0] vtx;

  logic        out_valid;
  logic [15:0] out_rx;
  logic [15:0] out_tx;
  logic [31:0] out_elapsed;

  logic [31:0]       lane_delta;
  logic [32:0]       trial;
  logic [32:0]       diff;
  logic              qbit;
  logic [31:0]       quot_next;
  logic              rx_busy;
  logic              tx_busy;
  logic [CODE_W-1:0] rx_code;
  logic [CODE_W-1:0] tx_code;
  logic              code_start;
  logic              out_load;

  assign job_take   = (state == B_IDLE) && job_avail;
  assign lane_delta = lane ? job_r.tx_delta : job_r.rx_delta;
  assign code_start = (state == B_CODE);

  // output register takes a word when it is empty or being drained
  assign out_load = (state == B_OUT) && (!out_valid || results.ready);

  // one restoring divide step
  always_comb begin
    trial     = {rem, num[31]};
    diff      = trial - {1'b0, job_r.elapsed};
    qbit      = (trial >= {1'b0, job_r.elapsed});
    quot_next = {num[30:0], qbit};
  end

  // coders for both lanes run side by side
  lre_coder #(.TABLE_DEPTH(TABLE_DEPTH)) u_rx_coder (
    .clk   (clk),
    .rst   (rst),
    .start (code_start),
    .value (vrx),
    .busy  (rx_busy),
    .code  (rx_code)
  );

  lre_coder #(.TABLE_DEPTH(TABLE_DEPTH)) u_tx_coder (
    .clk   (clk),
    .rst   (rst),
    .start (code_start),
    .value (vtx),
    .busy  (tx_busy),
    .code  (tx_code)
  );

  assign results.valid      = out_valid;
  assign results.rx_code    = out_rx;
  assign results.tx_code    = out_tx;
  assign results.elapsed_us = $signed(out_elapsed);

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      lane      <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_avail) begin
            job_r <= job;
            lane  <= 1'b0;
            if (job.scale) begin
              state <= B_MUL;
            end else begin
              vrx   <= job.rx_delta;
              vtx   <= job.tx_delta;
              state <= B_CODE;
            end
          end
        end
        B_MUL: begin
          prod  <= {32'd0, lane_delta} * {32'd0, nominal_us};
          state <= B_CHECK;
        end
        B_CHECK: begin
          // quotient of 2^32 or more saturates
          if (prod[63:32] >= job_r.elapsed) begin
            if (lane) begin
              vtx   <= SAT_MAX;
              state <= B_CODE;
            end else begin
              vrx   <= SAT_MAX;
              lane  <= 1'b1;
              state <= B_MUL;
            end
          end else begin
            rem   <= prod[63:32];
            num   <= prod[31:0];
            cnt   <= DIV_LAST;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (qbit) begin
            rem <= diff[31:0];
          end else begin
            rem <= trial[31:0];
          end
          num <= quot_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (lane) begin
              vtx   <= quot_next;
              state <= B_CODE;
            end else begin
              vrx   <= quot_next;
              lane  <= 1'b1;
              state <= B_MUL;
            end
          end
        end
        B_CODE: begin
          state <= B_WAIT;
        end
        B_WAIT: begin
          if (!rx_busy && !tx_busy) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            out_rx      <= 16'(rx_code);
            out_tx      <= 16'(tx_code);
            out_elapsed <= job_r.elapsed;
            state       <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/log_rate_encoder_tb.sv =====
// log_rate_encoder_tb: self-checking bench for the log rate encoder
// drives samples and config writes, predicts each result word and checks it
// depends on lre_pkg, lre_if and log_rate_encoder
`default_nettype none

module log_rate_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lre_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned SETTLE      = 250;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam bit [63:0]   Q62_UNIT    = 64'h4000_0000_0000_0000;

  // expected result word
  typedef struct packed {
    logic [15:0] rx_code;
    logic [15:0] tx_code;
    logic [31:0] elapsed;
  } rate_word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lre_in_if  samples_if();
  lre_out_if results_if();

  log_rate_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  // predictor state and register shadow
  bit [31:0]   log_floor [DEPTH];
  bit [31:0]   m_start;
  bit [31:0]   m_nominal;
  bit [30:0]   m_low;
  bit [30:0]   m_high;
  bit [31:0]   m_rx_last;
  bit [31:0]   m_tx_last;
  bit [31:0]   m_time_last;
  bit          m_primed;

  rate_word_t  expected_words[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          quiet;

  // running sample values for well-formed sequences
  bit [31:0]   cur_rx;
  bit [31:0]   cur_tx;
  bit [31:0]   cur_ts;

  always #5 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // (a * b) >> 62 in unsigned q2.62
  function automatic bit [63:0] q62_prod(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // table entry i is floor(2^(10 + 22*i/65536)) - 1024, fixed-point series
  task automatic build_log_floor();
    bit [63:0]   ln2;
    bit [63:0]   z;
    bit [63:0]   sum;
    bit [63:0]   term;
    bit [31:0]   y;
    int unsigned whole;
    ln2 = 0;
    for (int k = 1; k <= 62; k++) ln2 += (Q62_UNIT >> k) / 64'(k);
    for (int unsigned i = 0; i < DEPTH; i++) begin
      y     = 11 * i;
      whole = y >> 15;
      z     = q62_prod(ln2, {49'b0, y[14:0]} << 47);
      sum   = Q62_UNIT;
      term  = Q62_UNIT;
      for (int n = 1; n <= 40 && term != 0; n++) begin
        term = q62_prod(term, z) / 64'(n);
        sum  = sum + term;
      end
      log_floor[i] = 32'((sum >> (52 - whole)) - 64'd1024);
    end
  endtask

  // largest index whose entry does not exceed v, zero for zero
  function automatic bit [15:0] rate_code(input bit [31:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (v == 0) return 16'd0;
    lo = 0;
    hi = DEPTH - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (log_floor[mid] <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  // delta normalized to the nominal window, saturating
  function automatic bit [31:0] window_scale(input bit [31:0] delta, input bit [31:0] span);
    bit [63:0] q;
    q = ({32'b0, delta} * {32'b0, m_nominal}) / {32'b0, span};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // advance the predictor by one accepted sample
  task automatic predict_rate(input bit [31:0] stamp, input bit [31:0] rx,
                              input bit [31:0] tx, input bit [31:0] ts,
                              output bit emits, output rate_word_t w);
    bit [31:0] d;
    bit [31:0] vrx;
    bit [31:0] vtx;
    longint    el;
    emits = 1'b0;
    w     = '0;
    if (!m_primed || stamp < m_start) begin
      m_primed = 1'b1;
    end else begin
      d  = ts - m_time_last;
      el = longint'($signed(d));
      if (el > longint'(m_low) && el < longint'(m_high)) begin
        vrx = window_scale(rx - m_rx_last, d);
        vtx = window_scale(tx - m_tx_last, d);
      end else begin
        vrx = rx - m_rx_last;
        vtx = tx - m_tx_last;
      end
      w.rx_code = rate_code(vrx);
      w.tx_code = rate_code(vtx);
      w.elapsed = d;
      emits     = 1'b1;
    end
    m_rx_last   = rx;
    m_tx_last   = tx;
    m_time_last = ts;
  endtask

  // send one sample word and record its expected result
  task automatic send_sample(input bit [31:0] stamp, input bit [31:0] rx,
                             input bit [31:0] tx, input bit [31:0] ts);
    int unsigned gap;
    bit          emits;
    rate_word_t  w;
    gap = pick_gap();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid        <= 1'b1;
    samples_if.period_stamp <= stamp;
    samples_if.rx_count     <= rx;
    samples_if.tx_count     <= tx;
    samples_if.timestamp_us <= ts;
    do @(negedge clk); while (samples_if.ready !== 1'b1);
    @(posedge clk);
    cur_rx = rx;
    cur_tx = tx;
    cur_ts = ts;
    predict_rate(stamp, rx, tx, ts, emits, w);
    if (emits) expected_words.push_back(w);
  endtask

  // next sample of a sequence, given as deltas from the last one
  task automatic send_step(input bit [31:0] stamp, input bit [31:0] drx,
                           input bit [31:0] dtx, input bit [31:0] dts);
    send_sample(stamp, cur_rx + drx, cur_tx + dtx, cur_ts + dts);
  endtask

  // drop valid, wait out every expected word, then let the block settle
  task automatic wait_idle();
    samples_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input lre_reg_t idx, input bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_STAMP: m_start   = data;
      REG_NOMINAL:     m_nominal = data;
      REG_LOW_BOUND:   m_low     = data[30:0];
      REG_HIGH_BOUND:  m_high    = data[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_config(input bit [31:0] start, input bit [31:0] nominal,
                              input bit [31:0] low, input bit [31:0] high);
    write_reg(REG_START_STAMP, start);
    write_reg(REG_NOMINAL, nominal);
    write_reg(REG_LOW_BOUND, low);
    write_reg(REG_HIGH_BOUND, high);
  endtask

  // delta of widely spread magnitude
  function automatic bit [31:0] rand_mag();
    return $urandom >> $urandom_range(0, 32);
  endfunction

  // elapsed time mostly inside the window, sometimes on or past its edges
  function automatic bit [31:0] pick_elapsed();
    int unsigned q;
    int unsigned span;
    q    = $urandom_range(0, 9);
    span = (m_high > m_low) ? m_high - m_low : 0;
    if (q < 6 && span >= 2) return m_low + 1 + $urandom_range(0, span - 2);
    if (q == 6) return m_low;
    if (q == 7) return m_high;
    if (q == 8) return $urandom;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // window edges, saturation, wraps and negative time at reset settings
  task automatic test_directed_cases();
    send_sample(32'd0, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FF00);
    send_step(32'd1, 32'd0, 32'd0, 32'd10_000_000);
    send_step(32'd2, 32'd1, 32'd256, 32'd10_000_000);
    send_step(32'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'd9_000_001);
    send_step(32'd4, 32'd12345, 32'hFFFF_FFFF, 32'd9_000_000);
    send_step(32'd5, 32'h7FFF_FFFF, 32'd1, 32'd15_000_000);
    send_step(32'd6, 32'h0001_0000, 32'h00FF_FFFF, 32'd14_999_999);
    send_step(32'd7, 32'd5, 32'd7, 32'hFFFF_FFFB);
    send_step(32'd8, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
    send_step(32'd9, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
    send_step(32'd10, 32'd3, 32'd1024, 32'd0);
    send_step(32'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1);
    send_step(32'hFFFF_FFFF, 32'd1000, 32'd2047, 32'd10_000_000);
  endtask

  // start stamp, zero and full-scale nominal, empty and inverted windows
  task automatic test_config_extremes();
    wait_idle();
    write_reg(REG_START_STAMP, 32'd1000);
    send_step(32'd999, 32'd100, 32'd200, 32'd10_000_000);
    send_step(32'd1000, 32'd100, 32'd200, 32'd10_000_000);
    send_step(32'd0, 32'd5, 32'd6, 32'd10_000_000);
    send_step(32'hFFFF_FFFF, 32'd500, 32'd600, 32'd12_000_000);
    wait_idle();
    // bounds written with bit 31 set to check masking
    write_config(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_step(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_step(32'd2, 32'd77, 32'd1, 32'h7FFF_FFFE);
    send_step(32'd3, 32'd9, 32'd9, 32'd0);
    send_step(32'd4, 32'd9, 32'd9, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_NOMINAL, 32'd0);
    send_step(32'd5, 32'hFFFF_FFFF, 32'd123, 32'd1000);
    wait_idle();
    write_config(32'd0, 32'd10_000_000, 32'h7FFF_FFFF, 32'd0);
    send_step(32'd6, 32'd4096, 32'd8192, 32'd10_000_000);
    send_step(32'd7, 32'd1, 32'd2, 32'h4000_0000);
    wait_idle();
    write_config(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd2);
    send_step(32'hFFFF_FFFE, 32'd10, 32'd10, 32'd1);
    send_step(32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321, 32'd1);
    send_step(32'hFFFF_FFFF, 32'd3, 32'd4, 32'd2);
  endtask

  // phases of reset then random settings, mostly well-formed sample sequences
  task automatic test_random_traffic();
    bit [31:0]   period;
    bit [31:0]   low;
    bit [31:0]   high;
    bit [31:0]   nominal;
    int unsigned r;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      if (p == 0) begin
        write_config(START_RESET, NOMINAL_RESET, 32'(LOW_RESET), 32'(HIGH_RESET));
      end else begin
        case ($urandom_range(0, 3))
          0:       nominal = 32'd10_000_000;
          1:       nominal = $urandom;
          2:       nominal = $urandom_range(1, 1000);
          default: nominal = 32'hFFFF_FFFF;
        endcase
        low  = $urandom_range(0, 20_000_000);
        high = low + $urandom_range(2, 20_000_000);
        if ($urandom_range(0, 4) == 0) high = $urandom;
        write_config($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 1000)),
                     nominal, low, high);
      end
      quiet  = (p == 2);
      period = m_start;
      for (int i = 0; i < 92; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_sample($urandom, $urandom, $urandom, $urandom);
        end else if (r < 14 && m_start != 0) begin
          send_step($urandom_range(0, m_start - 1), rand_mag(), rand_mag(), $urandom);
        end else begin
          period += $urandom_range(1, 20);
          send_step(period, rand_mag(), rand_mag(), pick_elapsed());
        end
      end
      quiet = 1'b0;
    end
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      results_if.ready <= 1'b0;
      stall_left       <= stall_left - 1;
    end else begin
      results_if.ready <= 1'b1;
      stall_left       <= pick_gap();
    end
  end

  // compare each result word with the oldest expectation
  always @(negedge clk) begin
    rate_word_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected word: rx_code %0d tx_code %0d elapsed %0d",
                   results_if.rx_code, results_if.tx_code, results_if.elapsed_us);
      end else begin
        want = expected_words.pop_front();
        if (results_if.rx_code !== want.rx_code || results_if.tx_code !== want.tx_code ||
            results_if.elapsed_us !== want.elapsed) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: rx_code %0d/%0d tx_code %0d/%0d elapsed %0d/%0d (exp/got)",
                     want.rx_code, results_if.rx_code, want.tx_code, results_if.tx_code,
                     $signed(want.elapsed), results_if.elapsed_us);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_START_STAMP;
    cfg_data                = '0;
    samples_if.valid        = 1'b0;
    samples_if.period_stamp = '0;
    samples_if.rx_count     = '0;
    samples_if.tx_count     = '0;
    samples_if.timestamp_us = '0;
    results_if.ready        = 1'b0;
    stall_left              = 0;
    quiet                   = 1'b0;
    error_count             = 0;
    cycle_count             = 0;
    m_start                 = START_RESET;
    m_nominal               = NOMINAL_RESET;
    m_low                   = LOW_RESET;
    m_high                  = HIGH_RESET;
    m_rx_last               = '0;
    m_tx_last               = '0;
    m_time_last             = '0;
    m_primed                = 1'b0;
    cur_rx                  = '0;
    cur_tx                  = '0;
    cur_ts                  = '0;
    build_log_floor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/lre_pkg.sv
sv/lre_if.sv
sv/lre_front.sv
sv/lre_fifo.sv
sv/lre_coder.sv
sv/lre_back.sv
sv/log_rate_encoder.sv
verif/log_rate_encoder_tb.sv
